### design/btl_pkg.sv
// Shared types and constants for the band threshold lookup.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package btl_pkg;

  localparam int unsigned THR_W = 16;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned CFG_W = 5;

  localparam logic [THR_W-1:0] FIRST_THRESHOLD = THR_W'(1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic below;
  } status_t;

endpackage

`default_nettype wire

### design/btl_ctrl.sv
// Controller for the band threshold lookup: sequences load, search and result.
// Depends on btl_pkg for the state, command and status types.
`default_nettype none

module btl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             mode_i,
  input  btl_pkg::status_t      status_i,
  output btl_pkg::cmd_t         cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import btl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = (status_i.more && !status_i.below) ? ST_SEARCH : ST_RESULT;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (!status_i.more) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/btl_datapath.sv
// Datapath for the band threshold lookup: band tables, count register, search bounds.
// Depends on btl_pkg; driven by btl_ctrl commands.
`default_nettype none

module btl_datapath #(
  parameter int unsigned MAX_BANDS  = 16,
  parameter int unsigned SCORE_BITS = 16,
  localparam int unsigned IDX_W     = $clog2(MAX_BANDS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  btl_pkg::cmd_t                     cmd_i,
  output btl_pkg::status_t                  status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [btl_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic [IDX_W-1:0]             entry_index_i,
  input  wire logic [btl_pkg::THR_W-1:0]    entry_threshold_i,
  input  wire logic [btl_pkg::VAL_W-1:0]    entry_value_i,
  input  wire logic [SCORE_BITS-1:0]        score_i,
  output logic      [btl_pkg::VAL_W-1:0]    band_value_o,
  output logic                              below_first_o
);
  import btl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BANDS + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (SCORE_BITS > THR_W) ? SCORE_BITS : THR_W;

  logic [THR_W-1:0]      thr_mem [MAX_BANDS];
  logic [VAL_W-1:0]      val_mem [MAX_BANDS];
  logic [THR_W-1:0]      thr_rdata_q;
  logic [VAL_W-1:0]      val_rdata_q;

  logic [CFG_W-1:0]      band_count_q;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]      mid_q, mid_d, val_raddr;
  logic [SUM_W-1:0]      sum;
  logic [SCORE_BITS-1:0] score_q;
  logic                  below_q, below_d;
  logic                  idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      band_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (band_count_q == '0) begin
      used = CNT_W'(1);
    end else if (int'(band_count_q) > MAX_BANDS) begin
      used = CNT_W'(MAX_BANDS);
    end else begin
      used = CNT_W'(band_count_q);
    end
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    below_d = below_q;
    if (cmd_i.init) begin
      lo_d    = CNT_W'(1);
      hi_d    = used;
      below_d = CMP_W'(score_i) < CMP_W'(FIRST_THRESHOLD);
    end else if (cmd_i.step) begin
      if (CMP_W'(thr_rdata_q) <= CMP_W'(score_q)) begin
        lo_d = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        hi_d = CNT_W'(mid_q);
      end
    end
    sum       = SUM_W'(lo_d) + SUM_W'(hi_d);
    mid_d     = IDX_W'(sum >> 1);
    val_raddr = below_d ? '0 : IDX_W'(lo_d - CNT_W'(1));
  end

  assign status_o.more  = lo_d < hi_d;
  assign status_o.below = below_d;
  assign idx_ok         = int'(entry_index_i) < MAX_BANDS;

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    below_q <= below_d;
    mid_q   <= mid_d;
    if (cmd_i.init) begin
      score_q <= score_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && idx_ok) begin
      if (entry_index_i != '0) begin
        thr_mem[entry_index_i] <= entry_threshold_i;
      end
      val_mem[entry_index_i] <= entry_value_i;
    end
    thr_rdata_q <= thr_mem[mid_d];
    val_rdata_q <= val_mem[val_raddr];
  end

  assign band_value_o  = val_rdata_q;
  assign below_first_o = below_q;

endmodule

`default_nettype wire

### design/band_threshold_lookup.sv
// Top level of the band threshold lookup: binary search of a band table.
// Instantiates btl_ctrl and btl_datapath; depends on btl_pkg.
//
//   port group        dir  signals
//   request           in   start_i, mode_i, entry_index_i, entry_threshold_i,
//                          entry_value_i, score_i (busy_o is out)
//   result            out  done_o, band_value_o, below_first_o
//   band count write  in   cfg_we_i, cfg_wdata_i
//
// A load request writes the table at the accept edge; busy_o stays low.
// A query then runs search steps, at most ceil(log2(n)) with n the band count clamped
// to 1..MAX_BANDS, one threshold memory read per step, then a result state; a score
// below the first threshold goes straight to the result. The next request is taken
// once the controller is back in idle. done_o marks the result for exactly one cycle
// and cannot stall.
// Reset clears the controller and sets the band count to one; table entries are
// undefined until loaded.
`default_nettype none

module band_threshold_lookup #(
  parameter int unsigned MAX_BANDS  = 16,
  parameter int unsigned SCORE_BITS = 16,
  localparam int unsigned IDX_W     = $clog2(MAX_BANDS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic                       mode_i,
  input  wire logic [IDX_W-1:0]           entry_index_i,
  input  wire logic [btl_pkg::THR_W-1:0]  entry_threshold_i,
  input  wire logic [btl_pkg::VAL_W-1:0]  entry_value_i,
  input  wire logic [SCORE_BITS-1:0]      score_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [btl_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                            done_o,
  output logic      [btl_pkg::VAL_W-1:0]  band_value_o,
  output logic                            below_first_o
);
  import btl_pkg::*;

  cmd_t    cmd;
  status_t status;

  btl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  btl_datapath #(
    .MAX_BANDS  (MAX_BANDS),
    .SCORE_BITS (SCORE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .entry_index_i     (entry_index_i),
    .entry_threshold_i (entry_threshold_i),
    .entry_value_i     (entry_value_i),
    .score_i           (score_i),
    .band_value_o      (band_value_o),
    .below_first_o     (below_first_o)
  );

  a_done_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a query");

  a_query_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_QUERY) |=> busy_o)
    else $error("query request did not start a search");

  a_load_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_LOAD) |=> (!busy_o && !done_o))
    else $error("load request started a search");

  a_idle_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o))
    else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

### tb/band_threshold_lookup_tb.sv
// Self-checking testbench for band_threshold_lookup: loads band tables, sets the band count
// and sends queries, comparing every result with an in-bench binary search of the same table.
// Depends on btl_pkg and the band_threshold_lookup top level only.
`default_nettype none

module band_threshold_lookup_tb;
  import btl_pkg::*;

  localparam int unsigned BANDS        = 16;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_PASSES = 20;
  localparam int unsigned PASS_ITEMS   = 46;

  typedef struct packed {
    logic        mode;
    logic [3:0]  index;
    logic [15:0] thr;
    logic [15:0] value;
    logic [15:0] score;
  } band_request_t;

  typedef struct packed {
    logic [15:0] value;
    logic        below;
  } band_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        mode_i = MODE_LOAD;
  logic [3:0]  entry_index_i = '0;
  logic [15:0] entry_threshold_i = '0;
  logic [15:0] entry_value_i = '0;
  logic [15:0] score_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        done_o;
  logic [15:0] band_value_o;
  logic        below_first_o;

  logic [15:0]  thr_table [BANDS];
  logic [15:0]  val_table [BANDS];
  logic [4:0]   bands_cfg;
  band_result_t band_results[$];

  bit          sender_gaps = 1'b1;
  int unsigned mismatches = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;

  band_threshold_lookup dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mode_i            (mode_i),
    .entry_index_i     (entry_index_i),
    .entry_threshold_i (entry_threshold_i),
    .entry_value_i     (entry_value_i),
    .score_i           (score_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .band_value_o      (band_value_o),
    .below_first_o     (below_first_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] want, got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  function automatic void classify_request(input band_request_t req);
    band_result_t res;
    int unsigned  lo, hi, mid;
    if (req.mode == MODE_LOAD) begin
      if (req.index != 4'd0) thr_table[req.index] = req.thr;
      val_table[req.index] = req.value;
      n_loads++;
    end else begin
      if (req.score < thr_table[0]) begin
        res.value = val_table[0];
        res.below = 1'b1;
      end else begin
        lo = 1;
        hi = (bands_cfg == 0) ? 1 : (bands_cfg > BANDS) ? BANDS : bands_cfg;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (thr_table[mid] <= req.score) lo = mid + 1;
          else hi = mid;
        end
        res.value = val_table[lo-1];
        res.below = 1'b0;
      end
      band_results = {band_results, res};
      n_queries++;
    end
  endfunction

  always @(posedge clk_i) begin
    band_result_t want;
    if (rst_ni && done_o) begin
      if (band_results.size() == 0) begin
        report_mismatch("result with no query waiting", 16'h0, band_value_o);
      end else begin
        want = band_results.pop_front();
        if (band_value_o !== want.value) report_mismatch("band_value", want.value, band_value_o);
        if (below_first_o !== want.below)
          report_mismatch("below_first", 16'(want.below), 16'(below_first_o));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic m, input logic [3:0] idx,
                              input logic [15:0] thr, val, sc);
    band_request_t req;
    start_i           <= 1'b1;
    mode_i            <= m;
    entry_index_i     <= idx;
    entry_threshold_i <= thr;
    entry_value_i     <= val;
    score_i           <= sc;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    req = '{m, idx, thr, val, sc};
    classify_request(req);
    if (sender_gaps && $urandom_range(0, 99) < 19) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_query(input logic [15:0] sc);
    send_request(MODE_QUERY, 4'($urandom), 16'($urandom), 16'($urandom), sc);
  endtask

  task automatic drain_and_settle();
    start_i <= 1'b0;
    while (band_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_band_count(input logic [4:0] count);
    cfg_wdata_i <= count;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    bands_cfg = count;
    cfg_we_i  <= 1'b0;
    n_settings++;
  endtask

  task automatic load_table(input bit scrambled);
    int unsigned i, nt;
    logic [15:0] t;
    t = FIRST_THRESHOLD;
    for (i = 0; i < BANDS; i++) begin
      if (i != 0) begin
        if (scrambled) begin
          t = 16'($urandom);
        end else if ($urandom_range(0, 99) >= 20) begin
          nt = t + $urandom_range(1, 9000);
          t  = (nt > 16'hFFFF) ? 16'hFFFF : nt[15:0];
        end
      end
      send_request(MODE_LOAD, i[3:0], (i == 0) ? 16'($urandom) : t, 16'($urandom),
                   16'($urandom));
    end
  endtask

  task automatic test_table_load();
    logic [15:0] thr_list [BANDS];
    int unsigned i;
    thr_list = '{16'hFFFF, 16'd2, 16'd5, 16'd5, 16'd5, 16'd100, 16'd1000, 16'd4000,
                 16'd9000, 16'd20000, 16'd30000, 16'd40000, 16'd50000, 16'd60000,
                 16'hFFFE, 16'hFFFF};
    write_band_count(5'd16);
    for (i = 0; i < BANDS; i++) begin
      send_request(MODE_LOAD, i[3:0], thr_list[i],
                   (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom),
                   (i == 0) ? 16'hFFFF : 16'h0000);
    end
  endtask

  task automatic test_score_edges();
    send_query(16'h0000);
    send_query(16'h0001);
    send_query(16'h0004);
    send_query(16'h0005);
    send_query(16'hFFFE);
    send_query(16'hFFFF);
  endtask

  task automatic test_band_count_one();
    drain_and_settle();
    write_band_count(5'd1);
    send_query(16'hFFFF);
    send_query(16'h0000);
  endtask

  task automatic test_random_traffic();
    logic [4:0]  extremes [6];
    int unsigned p, k, j;
    logic [3:0]  idx;
    logic [15:0] sc;
    extremes = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    for (p = 0; p < RANDOM_PASSES; p++) begin
      sender_gaps = (p < 8 || p > 10);
      drain_and_settle();
      if (p < 6) write_band_count(extremes[p]);
      else if (p % 3 == 0) write_band_count(5'($urandom_range(0, 31)));
      else write_band_count(5'($urandom_range(1, 16)));
      load_table(p % 4 == 3);
      for (k = 0; k < PASS_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3) drain_and_settle();
        if ($urandom_range(0, 99) < 12) begin
          idx = 4'($urandom);
          send_request(MODE_LOAD, idx,
                       $urandom_range(0, 1) ? thr_table[idx] : 16'($urandom),
                       16'($urandom), 16'($urandom));
        end else begin
          j = $urandom_range(0, 9);
          case (j)
            0:       sc = 16'h0000;
            1:       sc = 16'hFFFF;
            2, 3, 4: sc = 16'($urandom);
            default: sc = 16'(thr_table[$urandom_range(0, BANDS - 1)]
                              + $urandom_range(0, 2) - 1);
          endcase
          send_query(sc);
        end
      end
    end
  endtask

  initial begin
    thr_table[0] = FIRST_THRESHOLD;
    bands_cfg    = 5'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_score_edges();
    test_band_count_one();
    test_random_traffic();
    drain_and_settle();
    $display("Sent %0d table loads and %0d queries under %0d band count settings",
             n_loads, n_queries, n_settings);
    $display("Checked %0d results, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && band_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
